/* src/cu_pkg.sv */
// ============================================================================
// Combination unranking package
// Widths and register indexes for the unranking core and its coefficient
// ROM, and the binomial coefficient table that the ROM is built from.
// ============================================================================
package cu_pkg;

    localparam int MAX_CELLS  = 64;
    localparam int MAX_PICKS  = 8;

    localparam int RANK_W     = 36;
    localparam int BINOM_W    = 33;   // C(64, 8) = 4426165368 fits in 33 bits
    localparam int CNT_W      = 7;    // holds 0..MAX_CELLS
    localparam int PICK_W     = 4;    // holds 0..MAX_PICKS and register values
    localparam int POS_W      = 6;
    localparam int BW_W       = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SPACES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PICK_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOARD_WIDTH  = 2'd2;

    typedef logic [BINOM_W-1:0] binom_t;
    typedef logic [0:MAX_CELLS][0:MAX_PICKS][BINOM_W-1:0] binom_tab_t;

    // Pascal's triangle, built at elaboration. Entries with k > n are zero.
    function automatic binom_tab_t binom_table();
        binom_tab_t t;
        t = '0;
        for (int n = 0; n <= MAX_CELLS; n++)
        begin
            for (int k = 0; k <= MAX_PICKS; k++)
            begin
                if (k == 0)
                begin
                    t[n][k] = binom_t'(1);
                end
                else if (n == 0)
                begin
                    t[n][k] = '0;
                end
                else
                begin
                    t[n][k] = t[n-1][k-1] + t[n-1][k];
                end
            end
        end
        return t;
    endfunction

endpackage

/* src/cu_binom_rom.sv */
// ============================================================================
// Binomial coefficient ROM
// Synchronous read of C(n, k) for n up to 64 and k up to 8.
// The read register holds its value while the read enable is low.
// ============================================================================
module cu_binom_rom (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [cu_pkg::CNT_W-1:0]  rd_n,
    input  logic [cu_pkg::PICK_W-1:0] rd_k,
    output cu_pkg::binom_t            rd_data
);

    localparam cu_pkg::binom_tab_t BINOM = cu_pkg::binom_table();

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= BINOM[rd_n][rd_k];
        end
    end

endmodule

/* src/combination_unrank_core.sv */
// ============================================================================
// Combination unranking core
// Turns a lexicographic rank into the chosen cells of a k-subset, one result
// per chosen cell, with its row and column on the configured board.
// ============================================================================
// A rank arrives as one request on the slave side and comes back as
// pick_count results on the master side, in ascending cell order, the last one
// marked by tlast. A rank that is out of range for the configured
// total_spaces and pick_count, or a configuration that is itself out of range,
// gives one result with tuser set and position, row and column zero. The
// binomial coefficients live in a synchronous ROM with one read port; each
// step of the walk that does not end it reads the coefficient that the next
// cell needs, so the walk covers one candidate cell per cycle except while a
// chosen cell waits for the output register to drain. A rank is accepted in
// the idle state, checked against C(total_spaces, pick_count) in the range
// check and then walked cell by cell up to and including the last chosen
// one; an error result also waits for the output register to drain. The
// next rank is accepted while the last result of the previous one still
// waits in the output register. Row and column are kept as running
// counters beside the cell index, so no divider is needed; a board width
// of zero leaves row at zero and column equal to position.
// Configuration must only be written while the core is idle. There is no
// clearing pass after reset.
// ============================================================================
module combination_unrank_core (
    input  logic                         clk,
    input  logic                         rst_n,
    // Configuration write port.
    input  logic                         cfg_we,
    input  logic [cu_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [cu_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Rank requests.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [39:0]                  s_tdata,   // [35:0] rank, [39:36] zero
    // Results.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [23:0]                  m_tdata,   // [5:0] position, [11:6] row,
                                                    // [17:12] column, [23:18] zero
    output logic                         m_tlast,   // last
    output logic                         m_tuser    // rank_error
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;

    localparam int CNT_W  = cu_pkg::CNT_W;
    localparam int PICK_W = cu_pkg::PICK_W;
    localparam int POS_W  = cu_pkg::POS_W;
    localparam int RANK_W = cu_pkg::RANK_W;

    // Configuration registers.
    logic [CNT_W-1:0]      total_spaces_reg;
    logic [PICK_W-1:0]     pick_count_reg;
    logic [cu_pkg::BW_W-1:0] board_width_reg;

    // Sequencer state.
    logic [1:0]            state_reg, state_next;
    logic [RANK_W-1:0]     rank_reg, rank_next;
    logic [POS_W-1:0]      cell_reg, cell_next;
    logic [PICK_W-1:0]     left_reg, left_next;
    logic [POS_W-1:0]      row_reg, row_next;
    logic [POS_W-1:0]      col_reg, col_next;

    // Output register.
    logic                  out_valid_reg, out_valid_next;
    logic [POS_W-1:0]      out_pos_reg, out_pos_next;
    logic [POS_W-1:0]      out_row_reg, out_row_next;
    logic [POS_W-1:0]      out_col_reg, out_col_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_err_reg, out_err_next;

    // ROM port.
    logic                  rom_en;
    logic [CNT_W-1:0]      rom_n;
    logic [PICK_W-1:0]     rom_k;
    cu_pkg::binom_t        rom_q;

    logic                  out_free;
    logic                  cfg_bad;
    logic [RANK_W-1:0]     binom_ext;
    logic                  take;
    logic [CNT_W-1:0]      col_inc;

    cu_binom_rom u_rom (
        .clk     (clk),
        .rd_en   (rom_en),
        .rd_n    (rom_n),
        .rd_k    (rom_k),
        .rd_data (rom_q)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    assign cfg_bad = (pick_count_reg == '0) ||
                     (pick_count_reg > PICK_W'(cu_pkg::MAX_PICKS)) ||
                     (total_spaces_reg == '0) ||
                     (total_spaces_reg > CNT_W'(cu_pkg::MAX_CELLS)) ||
                     ({3'b0, pick_count_reg} > total_spaces_reg);

    assign binom_ext = {{(RANK_W - cu_pkg::BINOM_W){1'b0}}, rom_q};
    assign take      = (rank_reg < binom_ext);
    assign col_inc   = {1'b0, col_reg} + CNT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        rank_next      = rank_reg;
        cell_next      = cell_reg;
        left_next      = left_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_pos_next   = out_pos_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        rom_en         = 1'b0;
        rom_n          = '0;
        rom_k          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    // Fetch C(n, k) for the range check; clamp the address so a
                    // bad configuration still reads inside the table.
                    rank_next  = s_tdata[RANK_W-1:0];
                    rom_en     = 1'b1;
                    rom_n      = (total_spaces_reg > CNT_W'(cu_pkg::MAX_CELLS)) ?
                                 CNT_W'(cu_pkg::MAX_CELLS) : total_spaces_reg;
                    rom_k      = (pick_count_reg > PICK_W'(cu_pkg::MAX_PICKS)) ?
                                 PICK_W'(cu_pkg::MAX_PICKS) : pick_count_reg;
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                if (cfg_bad || !take)
                begin
                    // Error result waits until the output register is free.
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_pos_next   = '0;
                        out_row_next   = '0;
                        out_col_next   = '0;
                        out_last_next  = 1'b1;
                        out_err_next   = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    cell_next  = '0;
                    left_next  = pick_count_reg;
                    row_next   = '0;
                    col_next   = '0;
                    rom_en     = 1'b1;
                    rom_n      = total_spaces_reg - CNT_W'(1);
                    rom_k      = pick_count_reg - PICK_W'(1);
                    state_next = ST_WALK;
                end
            end

            ST_WALK:
            begin
                // rom_q holds C(n - cell - 1, left - 1). A chosen cell stalls
                // the walk while the output register is occupied.
                if (!(take && !out_free))
                begin
                    if (take)
                    begin
                        left_next      = left_reg - PICK_W'(1);
                        out_valid_next = 1'b1;
                        out_pos_next   = cell_reg;
                        out_row_next   = row_reg;
                        out_col_next   = col_reg;
                        out_last_next  = (left_reg == PICK_W'(1));
                        out_err_next   = 1'b0;
                    end
                    else
                    begin
                        rank_next = rank_reg - binom_ext;
                    end

                    cell_next = cell_reg + POS_W'(1);
                    if ((board_width_reg != '0) && (col_inc == board_width_reg))
                    begin
                        col_next = '0;
                        row_next = row_reg + POS_W'(1);
                    end
                    else
                    begin
                        col_next = col_inc[POS_W-1:0];
                    end

                    if (take && (left_reg == PICK_W'(1)))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rom_en = 1'b1;
                        rom_n  = total_spaces_reg - {1'b0, cell_reg} - CNT_W'(2);
                        rom_k  = left_next - PICK_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_spaces_reg <= CNT_W'(64);
            pick_count_reg   <= PICK_W'(1);
            board_width_reg  <= cu_pkg::BW_W'(8);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                cu_pkg::CFG_TOTAL_SPACES: total_spaces_reg <= cfg_wdata;
                cu_pkg::CFG_PICK_COUNT:   pick_count_reg   <= cfg_wdata[PICK_W-1:0];
                cu_pkg::CFG_BOARD_WIDTH:  board_width_reg  <= cfg_wdata;
                default:                  ;
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rank_reg     <= rank_next;
        cell_reg     <= cell_next;
        left_reg     <= left_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        out_pos_reg  <= out_pos_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_col_reg, out_row_reg, out_pos_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_err_reg;

    // An error result is always the only, and so the last, result of a rank.
    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("error result without last flag");

    // The walk always has picks outstanding.
    a_walk_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (left_reg != '0))
        else $error("walk running with no picks left");

    // The walk never runs past the configured number of cells.
    a_walk_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> ({1'b0, cell_reg} < total_spaces_reg))
        else $error("walk ran past the last cell");

    // An accepted rank always goes to the range check next.
    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_CHECK))
        else $error("accepted rank did not enter the range check");

endmodule
